// File: src/binary_to_decimal_ascii_defines.svh
// Assertion helpers for the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define B2DA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define B2DA_ASSERT(lbl, clk, rst_n, prop, msg)
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/b2da_pkg.sv
package b2da_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 10;

	// binary bits folded into the digit chain per clock
	localparam int STEPS_PER_CYCLE = 8;

	localparam int          DIGIT_W    = 4;
	localparam logic [5:0]  ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: src/binary_to_decimal_ascii.sv
// Binary to decimal text. Pulse start while busy is low to hand in one word on
// value; the block then turns it into ASCII digits, most significant first, with
// leading zeros suppressed (zero gives a single '0'). Each digit appears on
// character for exactly one cycle with strobe high, and last marks the final,
// least significant digit. The receiver cannot stall: digits of one word come in
// consecutive cycles and must be taken as they appear. Conversion runs through a
// row of MAX_DIGITS decimal cells (shift and add-3), folding 8 binary bits into
// the row per clock until the whole word is in; a scan step then finds the
// leading digit, and the digits are shown from there down. A new word is
// taken in the cycle that shows the last digit of the previous one; while
// busy is high no new word is taken. If a value has more digits than
// MAX_DIGITS, only the low MAX_DIGITS digits are shown, all of them, zeros
// included.
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii
	import b2da_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   busy,
	output logic                   strobe,
	output logic [5:0]             character,
	output logic                   last
);

	// conversion cycles, and the value padded at the top to whole cycles
	localparam int CYCLES = (VALUE_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
	localparam int PW     = CYCLES * STEPS_PER_CYCLE;
	localparam int CNT_W  = $clog2(CYCLES + 1);
	localparam int IDX_W  = $clog2(MAX_DIGITS);

	state_t state_q, state_d;

	logic accept;
	logic shift;
	logic scan;
	logic emit;

	logic [PW-1:0]    value_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lead;

	logic             strobe_q;
	logic             last_q;
	logic [5:0]       char_q;

	cell_ctrl_t                 ctrl;
	logic [STEPS_PER_CYCLE-1:0] chain [MAX_DIGITS+1];
	logic [DIGIT_W-1:0]         digits [MAX_DIGITS];

	// ---------------------------------------------------------------------
	// Sequencer: idle, shift the value through the cells, find the leading
	// digit, then walk down to digit zero.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		shift   = 1'b0;
		scan    = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					accept  = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				shift = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan    = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit = 1'b1;
				if (idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// ---------------------------------------------------------------------
	// Binary source: feed the top bits of the word into cell zero, most
	// significant bit first, and advance the word by one cycle's worth of bits.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= PW'(value);
		end else if (shift) begin
			value_q <= value_q << STEPS_PER_CYCLE;
		end
	end

	for (genvar s = 0; s < STEPS_PER_CYCLE; s++) begin : g_src
		assign chain[0][s] = value_q[PW-1-s];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= CNT_W'(CYCLES - 1);
			ovf_q <= 1'b0;
		end else if (shift) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			// any carry out of the top cell means the value has more digits
			ovf_q <= ovf_q | (|chain[MAX_DIGITS]);
		end
	end

	// ---------------------------------------------------------------------
	// Decimal cell row: each cell keeps one digit and hands its carries up.
	// ---------------------------------------------------------------------
	assign ctrl.clear = accept;
	assign ctrl.shift = shift;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		b2da_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bits_in  (chain[i]),
			.bits_out (chain[i+1]),
			.digit    (digits[i])
		);
	end

	// Leading digit: the highest nonzero cell, or the top cell when digits
	// were dropped off the top; a zero value leaves cell zero.
	always_comb begin
		lead = '0;
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (digits[i] != '0) begin
				lead = IDX_W'(i);
			end
		end
		if (ovf_q) begin
			lead = IDX_W'(MAX_DIGITS - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (scan) begin
			idx_q <= lead;
		end else if (emit && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: hold each digit for one cycle under the strobe.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= ASCII_ZERO + {2'b00, digits[idx_q]};
			last_q <= (idx_q == '0);
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`B2DA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !strobe, "not started")
	`B2DA_ASSERT_NEXT(a_digits_back, clk, arst_n, strobe && !last, strobe, "gap in digit run")
	`B2DA_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && last, !strobe, "digit after last")
	`B2DA_ASSERT(a_strobe_busy, clk, arst_n, !strobe || busy || last, "digit shown while idle")

endmodule

// File: src/b2da_cell.sv
module b2da_cell
	import b2da_pkg::*;
(
	input  logic                       clk,
	input  cell_ctrl_t                 ctrl,
	input  logic [STEPS_PER_CYCLE-1:0] bits_in,
	output logic [STEPS_PER_CYCLE-1:0] bits_out,
	output logic [DIGIT_W-1:0]         digit
);

	localparam logic [DIGIT_W-1:0] ADJ_MIN = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] ADJ_ADD = DIGIT_W'(3);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] digit_d;

	// one add-3 and shift per step; the carry of each step feeds the cell above
	always_comb begin
		logic [DIGIT_W-1:0] d;
		logic [DIGIT_W-1:0] adj;
		d = digit_q;
		bits_out = '0;
		for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
			adj = (d >= ADJ_MIN) ? d + ADJ_ADD : d;
			bits_out[s] = adj[DIGIT_W-1];
			d = {adj[DIGIT_W-2:0], bits_in[s]};
		end
		digit_d = d;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= digit_d;
		end
	end

	assign digit = digit_q;

endmodule

// File: dv/binary_to_decimal_ascii_test.sv
module binary_to_decimal_ascii_test;
	import b2da_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RADIX = 10;

	typedef struct {
		logic [5:0] character;
		logic       last;
	} ascii_digit_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic [VALUE_WIDTH_DEF-1:0] value;
	logic                       busy;
	logic                       strobe;
	logic [5:0]                 character;
	logic                       last;

	// Digits still owed by the block, oldest first.
	ascii_digit_t pending_digits[$];
	int           mismatch_count;
	int           sender_idle_pct;

	binary_to_decimal_ascii u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Split the word into decimal digits by repeated division, keep at most
	// MAX_DIGITS_DEF of the low digits, and queue them most significant first.
	function automatic void queue_decimal_digits(input logic [VALUE_WIDTH_DEF-1:0] word);
		logic [DIGIT_W-1:0]         digits [MAX_DIGITS_DEF];
		logic [VALUE_WIDTH_DEF-1:0] rest;
		int                         count;
		ascii_digit_t               d;
		rest  = word;
		count = 0;
		if (rest == 0) begin
			digits[0] = '0;
			count     = 1;
		end else begin
			while (rest != 0 && count < MAX_DIGITS_DEF) begin
				digits[count] = DIGIT_W'(rest % RADIX);
				rest          = rest / RADIX;
				count++;
			end
		end
		for (int k = count - 1; k >= 0; k--) begin
			d.character = ASCII_ZERO + 6'(digits[k]);
			d.last      = (k == 0);
			pending_digits.push_back(d);
		end
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// Compare every strobed digit against the oldest one still owed.
	always @(posedge clk) begin
		ascii_digit_t want;
		if (arst_n && strobe) begin
			if (pending_digits.size() == 0) begin
				flag_mismatch($sformatf("unexpected digit: character %0d last %0b",
					character, last));
			end else begin
				want = pending_digits.pop_front();
				if (character !== want.character)
					flag_mismatch($sformatf("character: expected %0d, actual %0d",
						want.character, character));
				if (last !== want.last)
					flag_mismatch($sformatf("last: expected %0b, actual %0b",
						want.last, last));
			end
		end
	end

	// Hand in one word: hold start until the block takes it, then either keep
	// start up for the next word or drop it for a random gap.
	task automatic send_word(input logic [VALUE_WIDTH_DEF-1:0] word);
		start <= 1'b1;
		value <= word;
		do @(posedge clk); while (busy);
		queue_decimal_digits(word);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			value <= $urandom;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(20, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drop start and wait until the block has shown every owed digit.
	task automatic wait_digits_drained();
		start <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	// Favor values of every digit length; full-range words cover the top bits.
	function automatic logic [VALUE_WIDTH_DEF-1:0] pick_word();
		longint unsigned lo, hi, span;
		int              len;
		if ($urandom_range(3) == 0)
			return $urandom;
		len = $urandom_range(1, MAX_DIGITS_DEF);
		hi  = 1;
		for (int i = 0; i < len; i++)
			hi = hi * RADIX;
		lo = (len == 1) ? 0 : hi / RADIX;
		hi = hi - 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		span = hi - lo + 1;
		return VALUE_WIDTH_DEF'(lo + ({$urandom, $urandom} % span));
	endfunction

	task automatic test_edge_values();
		logic [VALUE_WIDTH_DEF-1:0] edges[$];
		edges = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd105, 32'd1005,
			32'd909, 32'd123456789, 32'd999999999, 32'd1000000000,
			32'd1000000001, 32'd2147483647, 32'd2147483648, 32'd4294967294,
			32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000,
			32'd10000, 32'd65535};
		sender_idle_pct = 0;
		foreach (edges[i])
			send_word(edges[i]);
	endtask

	// Pause with the pipe empty, then restart from cold with zero and the top.
	task automatic test_pause_after_drain();
		wait_digits_drained();
		@(posedge clk);
		send_word(32'd0);
		send_word(32'hFFFF_FFFF);
		wait_digits_drained();
	endtask

	task automatic test_random_words(input int idle_pct, input int count);
		sender_idle_pct = idle_pct;
		repeat (count)
			send_word(pick_word());
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_pause_after_drain();
		test_random_words(0, 110);
		test_random_words(49, 110);
		test_random_words(8, 110);

		wait_digits_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
